// ===== rtl/core/rpa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the refcounted page allocator.
// Depends on nothing; the front end, the back end and the core top use it.
package rpa_pkg;

	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 3;
	localparam int FP_W     = 20;
	localparam int PL_W     = 21;
	localparam int CFG_IDX_W = 1;

	localparam logic [PL_W-1:0] PL_RESET = 21'd557056;
	localparam logic [FP_W-1:0] FP_RESET = 20'd0;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'd1;

	localparam logic [FUNC_W-1:0] FN_ALLOC  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_FREE   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INCREF = 3'd2;
	localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_INIT   = 3'd4;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NO_PAGE   = 3'd1,
		ST_BAD_ADDR  = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_UNDERFLOW = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		K_ALLOC  = 3'd0,
		K_FREE   = 3'd1,
		K_INCREF = 3'd2,
		K_READ   = 3'd3,
		K_INIT   = 3'd4,
		K_BAD    = 3'd5,
		K_NOP    = 3'd6
	} kind_t;

	localparam int KIND_W = 3;

	typedef enum logic [1:0] {
		BK_CLEAR = 2'd0,
		BK_IDLE  = 2'd1,
		BK_EXEC  = 2'd2,
		BK_INIT  = 2'd3
	} bk_state_t;

	typedef struct packed {
		logic clearing;
	} bk_status_t;

endpackage

// ===== rtl/core/rpa_fifo.sv =====
`timescale 1ns / 1ps
// Small register queue used between the front and back and for results.
// Depends on nothing.
module rpa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/rpa_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts transactions, checks addresses and classifies operations.
// Depends on rpa_pkg.
module rpa_front #(
	parameter int NUM_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12,
	parameter int ADDR_BITS  = 32,
	parameter int AW         = $clog2(NUM_PAGES)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [rpa_pkg::FUNC_W-1:0] func,
	input  logic [ADDR_BITS-1:0]       phys_addr,
	input  logic [rpa_pkg::FP_W-1:0]   first_page,
	input  logic [rpa_pkg::PL_W-1:0]   page_limit,
	input  rpa_pkg::bk_status_t        bk_status,
	output logic                       q_push,
	input  logic                       q_full,
	output rpa_pkg::kind_t             q_kind,
	output logic [AW-1:0]              q_off
);

	localparam int PGW = ADDR_BITS - PAGE_SHIFT;
	localparam int CW  = ((PGW > rpa_pkg::PL_W) ? PGW : rpa_pkg::PL_W) + 1;

	logic                       vld_s1;
	logic [rpa_pkg::FUNC_W-1:0] func_s1;
	logic [ADDR_BITS-1:0]       addr_s1;
	logic                       accept;
	logic                       aligned;
	logic                       addr_ok;
	logic [CW-1:0]              pg;
	logic [CW-1:0]              fpw;
	logic [CW-1:0]              plw;
	logic [CW-1:0]              diff;

	assign full   = bk_status.clearing || (vld_s1 && q_full);
	assign accept = push && !full;
	assign q_push = vld_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			addr_s1 <= phys_addr;
		end
	end

	always_comb begin
		aligned = (addr_s1[PAGE_SHIFT-1:0] == '0);
		pg      = CW'(addr_s1[ADDR_BITS-1:PAGE_SHIFT]);
		fpw     = CW'(first_page);
		plw     = CW'(page_limit);
		diff    = pg - fpw;
		addr_ok = aligned && (pg >= fpw) && (pg < plw) && (diff < CW'(NUM_PAGES));
		q_off   = diff[AW-1:0];
		case (func_s1)
			rpa_pkg::FN_ALLOC:  q_kind = rpa_pkg::K_ALLOC;
			rpa_pkg::FN_INIT:   q_kind = rpa_pkg::K_INIT;
			rpa_pkg::FN_FREE:   q_kind = addr_ok ? rpa_pkg::K_FREE : rpa_pkg::K_BAD;
			rpa_pkg::FN_INCREF: q_kind = addr_ok ? rpa_pkg::K_INCREF : rpa_pkg::K_BAD;
			rpa_pkg::FN_READ:   q_kind = addr_ok ? rpa_pkg::K_READ : rpa_pkg::K_BAD;
			default:            q_kind = rpa_pkg::K_NOP;
		endcase
	end

endmodule

// ===== rtl/core/rpa_back.sv =====
`timescale 1ns / 1ps
// Back end: count memory, free stack and the sequencer that carries out operations.
// Depends on rpa_pkg.
module rpa_back #(
	parameter int NUM_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12,
	parameter int COUNT_BITS = 8,
	parameter int ADDR_BITS  = 32,
	parameter int AW         = $clog2(NUM_PAGES)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [rpa_pkg::FP_W-1:0]     first_page,
	input  logic [rpa_pkg::PL_W-1:0]     page_limit,
	input  logic                         cmd_empty,
	input  rpa_pkg::kind_t               cmd_kind,
	input  logic [AW-1:0]                cmd_off,
	output logic                         cmd_pop,
	input  logic                         res_full,
	output logic                         res_push,
	output logic [ADDR_BITS-1:0]         res_page_addr,
	output logic [COUNT_BITS-1:0]        res_ref_count,
	output logic                         res_released,
	output logic [rpa_pkg::STATUS_W-1:0] res_status,
	output rpa_pkg::bk_status_t          bk_status
);

	localparam int DW = $clog2(NUM_PAGES + 1);
	localparam int SW = ((rpa_pkg::FP_W > AW) ? rpa_pkg::FP_W : AW) + 1;
	localparam int NW = (DW > rpa_pkg::PL_W + 1) ? DW : rpa_pkg::PL_W + 1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] ref_mem [NUM_PAGES];
	logic [AW-1:0]         stk_mem [NUM_PAGES];

	rpa_pkg::bk_state_t state_q, state_d;
	rpa_pkg::kind_t     kind_q;
	logic [AW-1:0]      off_q;
	logic [AW-1:0]      walk_q, walk_d;
	logic [DW-1:0]      depth_q, depth_d;
	logic [DW-1:0]      depth_m1;

	logic [COUNT_BITS-1:0] ref_rd_q;
	logic [AW-1:0]         stk_rd_q;
	logic                  ref_we;
	logic [AW-1:0]         ref_waddr;
	logic [COUNT_BITS-1:0] ref_wdata;
	logic                  stk_we;
	logic [AW-1:0]         stk_waddr;
	logic [AW-1:0]         stk_wdata;

	logic [SW-1:0]         page_sum;
	logic [NW-1:0]         span;
	logic [NW-1:0]         n_pages;
	logic [COUNT_BITS-1:0] count_dec;
	logic [COUNT_BITS-1:0] count_inc;

	assign depth_m1  = depth_q - 1'b1;
	assign page_sum  = SW'(first_page) + SW'(stk_rd_q);
	assign count_dec = ref_rd_q - 1'b1;
	assign count_inc = ref_rd_q + 1'b1;
	assign span      = NW'(page_limit) - NW'(first_page);

	always_comb begin
		if (page_limit <= rpa_pkg::PL_W'(first_page)) begin
			n_pages = '0;
		end else if (span > NW'(NUM_PAGES)) begin
			n_pages = NW'(NUM_PAGES);
		end else begin
			n_pages = span;
		end
	end

	always_ff @(posedge clk) begin
		ref_rd_q <= ref_mem[cmd_off];
		if (ref_we) begin
			ref_mem[ref_waddr] <= ref_wdata;
		end
	end

	always_ff @(posedge clk) begin
		stk_rd_q <= stk_mem[depth_m1[AW-1:0]];
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpa_pkg::BK_CLEAR;
			walk_q  <= '0;
			depth_q <= '0;
		end else begin
			state_q <= state_d;
			walk_q  <= walk_d;
			depth_q <= depth_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			kind_q <= cmd_kind;
			off_q  <= cmd_off;
		end
	end

	always_comb begin
		state_d       = state_q;
		walk_d        = walk_q;
		depth_d       = depth_q;
		cmd_pop       = 1'b0;
		res_push      = 1'b0;
		res_page_addr = '0;
		res_ref_count = '0;
		res_released  = 1'b0;
		res_status    = rpa_pkg::ST_OK;
		ref_we        = 1'b0;
		ref_waddr     = off_q;
		ref_wdata     = '0;
		stk_we        = 1'b0;
		stk_waddr     = depth_q[AW-1:0];
		stk_wdata     = off_q;
		bk_status.clearing = (state_q == rpa_pkg::BK_CLEAR);
		case (state_q)
			rpa_pkg::BK_CLEAR: begin
				ref_we    = 1'b1;
				ref_waddr = walk_q;
				if (walk_q == AW'(NUM_PAGES - 1)) begin
					walk_d  = '0;
					state_d = rpa_pkg::BK_IDLE;
				end else begin
					walk_d = walk_q + 1'b1;
				end
			end
			rpa_pkg::BK_IDLE: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					walk_d  = '0;
					state_d = (cmd_kind == rpa_pkg::K_INIT) ? rpa_pkg::BK_INIT : rpa_pkg::BK_EXEC;
				end
			end
			rpa_pkg::BK_INIT: begin
				ref_we    = 1'b1;
				ref_waddr = walk_q;
				stk_we    = 1'b1;
				stk_waddr = walk_q;
				stk_wdata = walk_q;
				if (walk_q == AW'(NUM_PAGES - 1)) begin
					walk_d   = '0;
					depth_d  = DW'(n_pages);
					res_push = 1'b1;
					state_d  = rpa_pkg::BK_IDLE;
				end else begin
					walk_d = walk_q + 1'b1;
				end
			end
			rpa_pkg::BK_EXEC: begin
				res_push = 1'b1;
				state_d  = rpa_pkg::BK_IDLE;
				case (kind_q)
					rpa_pkg::K_ALLOC: begin
						if (depth_q == '0) begin
							res_status = rpa_pkg::ST_NO_PAGE;
						end else begin
							depth_d       = depth_m1;
							ref_we        = 1'b1;
							ref_waddr     = stk_rd_q;
							ref_wdata     = COUNT_BITS'(1);
							res_ref_count = COUNT_BITS'(1);
							res_page_addr = ADDR_BITS'({page_sum, {PAGE_SHIFT{1'b0}}});
						end
					end
					rpa_pkg::K_FREE: begin
						if (ref_rd_q == '0) begin
							res_status = rpa_pkg::ST_UNDERFLOW;
						end else begin
							ref_we        = 1'b1;
							ref_wdata     = count_dec;
							res_ref_count = count_dec;
							if (count_dec == '0 && depth_q < DW'(NUM_PAGES)) begin
								stk_we       = 1'b1;
								depth_d      = depth_q + 1'b1;
								res_released = 1'b1;
							end
						end
					end
					rpa_pkg::K_INCREF: begin
						if (ref_rd_q == COUNT_MAX) begin
							res_status    = rpa_pkg::ST_OVERFLOW;
							res_ref_count = ref_rd_q;
						end else begin
							ref_we        = 1'b1;
							ref_wdata     = count_inc;
							res_ref_count = count_inc;
						end
					end
					rpa_pkg::K_READ: begin
						res_ref_count = ref_rd_q;
					end
					rpa_pkg::K_BAD: begin
						res_status = rpa_pkg::ST_BAD_ADDR;
					end
					default: begin
					end
				endcase
			end
			default: begin
				state_d = rpa_pkg::BK_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/refcounted_page_allocator_core.sv =====
`timescale 1ns / 1ps
// Refcounted page allocator: one result per operation, at most one in flight in the back end.
// Alloc, free, incref and read each read the count memory in the back end, then write back, and
// the back end takes no new operation before the last one is done; a result passes the front
// register, the command queue, the back end and the result queue. Init walks all NUM_PAGES
// entries in the back end. After reset a clearing pass over all NUM_PAGES entries zeroes
// the counts, during which full stays high; configuration writes are taken at any time.
module refcounted_page_allocator_core #(
	parameter int NUM_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12,
	parameter int COUNT_BITS = 8,
	parameter int ADDR_BITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [rpa_pkg::FUNC_W-1:0]    func,
	input  logic [ADDR_BITS-1:0]          phys_addr,
	output logic                          empty,
	input  logic                          pop,
	output logic [ADDR_BITS-1:0]          page_addr,
	output logic [COUNT_BITS-1:0]         ref_count,
	output logic                          released,
	output logic [rpa_pkg::STATUS_W-1:0]  status,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rpa_pkg::PL_W-1:0]      cfg_data
);

	localparam int AW    = $clog2(NUM_PAGES);
	localparam int CMD_W = rpa_pkg::KIND_W + AW;
	localparam int RES_W = ADDR_BITS + COUNT_BITS + 1 + rpa_pkg::STATUS_W;

	logic [rpa_pkg::FP_W-1:0] first_page_q;
	logic [rpa_pkg::PL_W-1:0] page_limit_q;

	rpa_pkg::bk_status_t bk_status;
	rpa_pkg::kind_t      f_kind;
	logic [AW-1:0]       f_off;
	logic                f_push;
	logic                cmdq_full;
	logic                cmdq_empty;
	logic                cmdq_pop;
	logic [CMD_W-1:0]    cmdq_rdata;
	rpa_pkg::kind_t      b_kind;
	logic [AW-1:0]       b_off;

	logic                         res_push;
	logic                         res_full;
	logic [ADDR_BITS-1:0]         r_page_addr;
	logic [COUNT_BITS-1:0]        r_ref_count;
	logic                         r_released;
	logic [rpa_pkg::STATUS_W-1:0] r_status;
	logic [RES_W-1:0]             resq_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_page_q <= rpa_pkg::FP_RESET;
			page_limit_q <= rpa_pkg::PL_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == rpa_pkg::CFG_FIRST_PAGE) begin
				first_page_q <= cfg_data[rpa_pkg::FP_W-1:0];
			end else if (cfg_index == rpa_pkg::CFG_PAGE_LIMIT) begin
				page_limit_q <= cfg_data;
			end
		end
	end

	rpa_front #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_SHIFT (PAGE_SHIFT),
		.ADDR_BITS  (ADDR_BITS),
		.AW         (AW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.phys_addr  (phys_addr),
		.first_page (first_page_q),
		.page_limit (page_limit_q),
		.bk_status  (bk_status),
		.q_push     (f_push),
		.q_full     (cmdq_full),
		.q_kind     (f_kind),
		.q_off      (f_off)
	);

	rpa_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  ({f_kind, f_off}),
		.full   (cmdq_full),
		.pop    (cmdq_pop),
		.rdata  (cmdq_rdata),
		.empty  (cmdq_empty)
	);

	assign b_kind = rpa_pkg::kind_t'(cmdq_rdata[CMD_W-1:AW]);
	assign b_off  = cmdq_rdata[AW-1:0];

	rpa_back #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_SHIFT (PAGE_SHIFT),
		.COUNT_BITS (COUNT_BITS),
		.ADDR_BITS  (ADDR_BITS),
		.AW         (AW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.first_page    (first_page_q),
		.page_limit    (page_limit_q),
		.cmd_empty     (cmdq_empty),
		.cmd_kind      (b_kind),
		.cmd_off       (b_off),
		.cmd_pop       (cmdq_pop),
		.res_full      (res_full),
		.res_push      (res_push),
		.res_page_addr (r_page_addr),
		.res_ref_count (r_ref_count),
		.res_released  (r_released),
		.res_status    (r_status),
		.bk_status     (bk_status)
	);

	rpa_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  ({r_page_addr, r_ref_count, r_released, r_status}),
		.full   (res_full),
		.pop    (pop),
		.rdata  (resq_rdata),
		.empty  (empty)
	);

	assign page_addr = resq_rdata[RES_W-1 -: ADDR_BITS];
	assign ref_count = resq_rdata[rpa_pkg::STATUS_W + 1 +: COUNT_BITS];
	assign released  = resq_rdata[rpa_pkg::STATUS_W];
	assign status    = resq_rdata[rpa_pkg::STATUS_W-1:0];

endmodule

// ===== sim/refcounted_page_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_page_allocator_core: directed and random operation
// streams are scored against an in-bench model of the page counts and the free stack.
// Depends on rpa_pkg and the allocator core; needs nothing else.
module refcounted_page_allocator_core_tb;

	localparam int NUM_PAGES   = 32768;
	localparam int PAGE_SHIFT  = 12;
	localparam int COUNT_MAX   = 255;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [31:0]      page_addr;
		logic [7:0]       ref_count;
		logic             released;
		rpa_pkg::status_t status;
	} page_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          push = 1'b0;
	logic                          full;
	logic [rpa_pkg::FUNC_W-1:0]    func = '0;
	logic [31:0]                   phys_addr = '0;
	logic                          empty;
	logic                          pop = 1'b0;
	logic [31:0]                   page_addr;
	logic [7:0]                    ref_count;
	logic                          released;
	logic [rpa_pkg::STATUS_W-1:0]  status;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rpa_pkg::PL_W-1:0]      cfg_data = '0;

	logic [7:0]   page_refs [NUM_PAGES];
	logic [14:0]  free_offsets [NUM_PAGES];
	int unsigned  free_top = 0;
	logic [rpa_pkg::FP_W-1:0] cur_first = rpa_pkg::FP_RESET;
	logic [rpa_pkg::PL_W-1:0] cur_limit = rpa_pkg::PL_RESET;
	logic [31:0]  held_addrs [$];
	page_result_t pending_results [$];

	int  cycles = 0;
	int  mismatches = 0;
	int  rx_hold_cycles = 0;
	bit  tx_idle_en = 1'b0;
	bit  rx_idle_en = 1'b0;

	refcounted_page_allocator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.phys_addr (phys_addr),
		.empty     (empty),
		.pop       (pop),
		.page_addr (page_addr),
		.ref_count (ref_count),
		.released  (released),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic bit page_offset_of(input logic [31:0] addr, output int unsigned off);
		int unsigned page;
		page = addr >> PAGE_SHIFT;
		off = 0;
		if (addr[PAGE_SHIFT-1:0] != '0)
			return 1'b0;
		if (page < cur_first || page >= cur_limit)
			return 1'b0;
		if (page - cur_first >= NUM_PAGES)
			return 1'b0;
		off = page - cur_first;
		return 1'b1;
	endfunction

	function automatic int unsigned managed_span();
		int unsigned span;
		span = (cur_limit > cur_first) ? cur_limit - cur_first : 0;
		if (span > NUM_PAGES)
			span = NUM_PAGES;
		return span;
	endfunction

	task automatic predict_page_op(input logic [rpa_pkg::FUNC_W-1:0] fn,
			input logic [31:0] addr);
		page_result_t r;
		int unsigned  off;
		int unsigned  n;
		logic [63:0]  wide_addr;
		r = '{32'd0, 8'd0, 1'b0, rpa_pkg::ST_OK};
		case (fn)
		rpa_pkg::FN_ALLOC: begin
			if (free_top == 0) begin
				r.status = rpa_pkg::ST_NO_PAGE;
			end else begin
				free_top--;
				off = free_offsets[free_top];
				page_refs[off] = 8'd1;
				r.ref_count = 8'd1;
				wide_addr = (64'(cur_first) + off) << PAGE_SHIFT;
				r.page_addr = wide_addr[31:0];
				held_addrs.push_back(r.page_addr);
				if (held_addrs.size() > 64)
					held_addrs.delete(0);
			end
		end
		rpa_pkg::FN_FREE: begin
			if (!page_offset_of(addr, off)) begin
				r.status = rpa_pkg::ST_BAD_ADDR;
			end else if (page_refs[off] == 0) begin
				r.status = rpa_pkg::ST_UNDERFLOW;
			end else begin
				page_refs[off] = page_refs[off] - 8'd1;
				r.ref_count = page_refs[off];
				if (page_refs[off] == 0 && free_top < NUM_PAGES) begin
					free_offsets[free_top] = 15'(off);
					free_top++;
					r.released = 1'b1;
				end
			end
		end
		rpa_pkg::FN_INCREF: begin
			if (!page_offset_of(addr, off)) begin
				r.status = rpa_pkg::ST_BAD_ADDR;
			end else if (page_refs[off] >= COUNT_MAX) begin
				r.status = rpa_pkg::ST_OVERFLOW;
				r.ref_count = page_refs[off];
			end else begin
				page_refs[off] = page_refs[off] + 8'd1;
				r.ref_count = page_refs[off];
			end
		end
		rpa_pkg::FN_READ: begin
			if (!page_offset_of(addr, off))
				r.status = rpa_pkg::ST_BAD_ADDR;
			else
				r.ref_count = page_refs[off];
		end
		rpa_pkg::FN_INIT: begin
			n = managed_span();
			for (int i = 0; i < NUM_PAGES; i++)
				page_refs[i] = '0;
			for (int i = 0; i < n; i++)
				free_offsets[i] = 15'(i);
			free_top = n;
			held_addrs.delete();
		end
		default: begin
		end
		endcase
		pending_results.push_back(r);
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_op(input logic [rpa_pkg::FUNC_W-1:0] fn, input logic [31:0] addr);
		while (tx_idle_en && $urandom_range(0, 99) < 18) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		func <= fn;
		phys_addr <= addr;
		do @(posedge clk); while (full);
		predict_page_op(fn, addr);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [rpa_pkg::CFG_IDX_W-1:0] idx,
			input logic [rpa_pkg::PL_W-1:0] data);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == rpa_pkg::CFG_FIRST_PAGE)
			cur_first = data[rpa_pkg::FP_W-1:0];
		else
			cur_limit = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_addr();
		int unsigned span;
		int unsigned r;
		logic [63:0] wide_addr;
		span = managed_span();
		r = $urandom_range(0, 99);
		if (r < 55 && held_addrs.size() > 0)
			return held_addrs[$urandom_range(0, held_addrs.size() - 1)];
		if (r < 90 && span > 0) begin
			wide_addr = (64'(cur_first) + $urandom_range(0, span - 1)) << PAGE_SHIFT;
			return wide_addr[31:0];
		end
		if (r < 95)
			return $urandom();
		return $urandom() & 32'hFFFF_F000;
	endfunction

	task automatic run_random_ops(input int count);
		int unsigned r;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 28)
				send_op(rpa_pkg::FN_ALLOC, $urandom());
			else if (r < 52)
				send_op(rpa_pkg::FN_FREE, pick_addr());
			else if (r < 74)
				send_op(rpa_pkg::FN_INCREF, pick_addr());
			else if (r < 92)
				send_op(rpa_pkg::FN_READ, pick_addr());
			else if (r < 96)
				send_op(3'($urandom_range(5, 7)), $urandom());
			else
				send_op(rpa_pkg::FN_FREE, $urandom());
		end
	endtask

	task automatic test_directed_ops();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		send_op(rpa_pkg::FN_ALLOC, 32'h0000_0000);
		send_op(rpa_pkg::FN_READ, 32'h0000_0000);
		send_op(rpa_pkg::FN_FREE, 32'h0000_0000);
		send_op(3'd5, 32'hFFFF_FFFF);
		send_op(3'd7, 32'h0000_0000);
		send_op(rpa_pkg::FN_READ, 32'h0000_0801);
		send_op(rpa_pkg::FN_READ, 32'h0800_0000);
		send_op(rpa_pkg::FN_INCREF, 32'hFFFF_F000);
		send_op(rpa_pkg::FN_INIT, 32'hFFFF_FFFF);
		// The stack is full here, so a page whose count drops to zero is not pushed back.
		send_op(rpa_pkg::FN_INCREF, 32'h0000_1000);
		send_op(rpa_pkg::FN_FREE, 32'h0000_1000);
		send_op(rpa_pkg::FN_ALLOC, 32'h0000_0000);
		send_op(rpa_pkg::FN_INCREF, 32'h07FF_F000);
		send_op(rpa_pkg::FN_FREE, 32'h07FF_F000);
		send_op(rpa_pkg::FN_FREE, 32'h07FF_F000);
		send_op(rpa_pkg::FN_FREE, 32'h07FF_F000);
		send_op(rpa_pkg::FN_ALLOC, 32'h0000_0000);
	endtask

	task automatic test_register_extremes();
		write_reg(rpa_pkg::CFG_FIRST_PAGE, 21'd1048575);
		write_reg(rpa_pkg::CFG_PAGE_LIMIT, 21'd1048576);
		send_op(rpa_pkg::FN_INIT, 32'h0000_0000);
		send_op(rpa_pkg::FN_ALLOC, 32'h0000_0000);
		send_op(rpa_pkg::FN_ALLOC, 32'h0000_0000);
		send_op(rpa_pkg::FN_FREE, 32'hFFFF_F000);
		write_reg(rpa_pkg::CFG_PAGE_LIMIT, 21'd0);
		send_op(rpa_pkg::FN_INIT, 32'h0000_0000);
		send_op(rpa_pkg::FN_ALLOC, 32'h0000_0000);
		write_reg(rpa_pkg::CFG_FIRST_PAGE, 21'd0);
		write_reg(rpa_pkg::CFG_PAGE_LIMIT, 21'd2);
		send_op(rpa_pkg::FN_INIT, 32'h0000_0000);
		send_op(rpa_pkg::FN_ALLOC, 32'hFFFF_FFFF);
		send_op(rpa_pkg::FN_ALLOC, 32'hFFFF_FFFF);
	endtask

	task automatic test_small_pool();
		int unsigned base;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (2) begin
			base = $urandom_range(0, 1048575 - 16);
			write_reg(rpa_pkg::CFG_FIRST_PAGE, 21'(base));
			write_reg(rpa_pkg::CFG_PAGE_LIMIT, 21'(base + $urandom_range(1, 12)));
			send_op(rpa_pkg::FN_INIT, $urandom());
			run_random_ops(90);
		end
	endtask

	task automatic test_large_pool();
		write_reg(rpa_pkg::CFG_FIRST_PAGE, 21'($urandom_range(0, 1048575 - NUM_PAGES)));
		write_reg(rpa_pkg::CFG_PAGE_LIMIT, 21'd1048576);
		send_op(rpa_pkg::FN_INIT, $urandom());
		run_random_ops(200);
	endtask

	task automatic test_count_saturation();
		logic [31:0] target;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_op(rpa_pkg::FN_ALLOC, $urandom());
		target = held_addrs[held_addrs.size() - 1];
		for (int k = 0; k < 258; k++) begin
			send_op(rpa_pkg::FN_INCREF, target);
			if (k % 64 == 0)
				send_op(rpa_pkg::FN_READ, target);
		end
		repeat (3) send_op(rpa_pkg::FN_FREE, target);
	endtask

	task automatic test_output_stall();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b1;
		wait_drained();
		@(posedge clk);
		rx_hold_cycles = 500;
		@(negedge clk);
		run_random_ops(60);
	endtask

	task automatic test_moved_base();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		write_reg(rpa_pkg::CFG_FIRST_PAGE, 21'd1048570);
		write_reg(rpa_pkg::CFG_PAGE_LIMIT, 21'd1048576);
		send_op(rpa_pkg::FN_INIT, $urandom());
		// Every offset on the stack but zero now lands past the top of the page space and wraps.
		write_reg(rpa_pkg::CFG_FIRST_PAGE, 21'd1048575);
		run_random_ops(40);
	endtask

	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			rx_hold_cycles--;
			pop <= 1'b0;
		end else begin
			pop <= !(rx_idle_en && $urandom_range(0, 99) < 18);
		end
	end

	always @(posedge clk) begin : check_result
		page_result_t exp_r;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("cycle %0d: result transaction with nothing outstanding", cycles);
			end else begin
				exp_r = pending_results.pop_front();
				if (page_addr !== exp_r.page_addr || ref_count !== exp_r.ref_count ||
						released !== exp_r.released || status !== exp_r.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("cycle %0d: expected addr %h count %0d rel %0b status %0d, %s %h %0d %0b %0d",
							cycles, exp_r.page_addr, exp_r.ref_count, exp_r.released,
							exp_r.status, "got", page_addr, ref_count, released, status);
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_PAGES; i++)
			page_refs[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_ops();
		test_register_extremes();
		test_small_pool();
		test_large_pool();
		test_count_saturation();
		test_output_stall();
		test_moved_base();
		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/rpa_pkg.sv
rtl/core/rpa_fifo.sv
rtl/core/rpa_front.sv
rtl/core/rpa_back.sv
rtl/core/refcounted_page_allocator_core.sv
sim/refcounted_page_allocator_core_tb.sv
